// ===== rtl/core/hjbt_pkg.sv =====
// hjbt_pkg: shared types and constants for the hash join build table
// beat structs, table entry layout, status codes and hash constants
// no dependencies
package hjbt_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 1024;
  localparam int unsigned KEY_W           = 31;
  localparam int unsigned CFG_W           = 4;
  localparam int unsigned SLOT_OUT_W      = 10;

  localparam logic [31:0] HASH_MULT        = 32'd2654435761;
  // "PROMO" with the first byte most significant
  localparam logic [39:0] PROMO_WORD       = 40'h50524F4D4F;
  localparam logic [CFG_W-1:0] SLOTS_LOG2_RST = 4'd10;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_MISS     = 3'd3,
    ST_BAD_KEY  = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] join_key;
    logic [39:0]        type_prefix;
  } in_beat_t;

  typedef struct packed {
    status_e                 status;
    logic [SLOT_OUT_W-1:0]   slot_index;
    logic                    promo_flag;
  } out_beat_t;

  // one table slot: a stored key of zero marks an empty slot
  typedef struct packed {
    logic             flag;
    logic [KEY_W-1:0] key;
  } entry_t;

  // write port request from the sequencer to the slot store
  typedef struct packed {
    logic   we;
    entry_t wdata;
  } store_wr_t;

endpackage

// ===== rtl/core/hjbt_hash.sv =====
// hjbt_hash: multiplicative hash, registered product, masked home slot
// depends on hjbt_pkg
module hjbt_hash #(
  parameter int unsigned AW = 10
) (
  input  logic          clk_i,
  input  logic          load_i,
  input  logic [31:0]   key_i,
  input  logic [AW-1:0] mask_i,
  output logic [AW-1:0] home_o
);
  import hjbt_pkg::*;

  logic [31:0] product_q;

  // low 32 bits of the product only
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      product_q <= key_i * HASH_MULT;
    end
  end

  assign home_o = product_q[AW-1:0] & mask_i;

endmodule

// ===== rtl/core/hjbt_store.sv =====
// hjbt_store: slot memory, one write port and one registered read port
// depends on hjbt_pkg
module hjbt_store #(
  parameter int unsigned TABLE_SLOTS = hjbt_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned AW          = $clog2(TABLE_SLOTS)
) (
  input  logic              clk_i,
  input  hjbt_pkg::store_wr_t wr_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [AW-1:0]     raddr_i,
  output hjbt_pkg::entry_t  rdata_o
);
  import hjbt_pkg::*;

  entry_t mem [TABLE_SLOTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[waddr_i] <= wr_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/hash_join_build_table.sv =====
// hash_join_build_table: build side of a hash join, linear probing table
// top level with the probe sequencer; uses hjbt_pkg, hjbt_hash, hjbt_store
//
// Each input beat either inserts a positive key with a promo flag (set when the
// first five type bytes read "PROMO") or looks a key up. The home slot is the
// low bits of key * 2654435761 masked to 2^active_slots_log2 slots (0 counts as
// 1, values above log2(TABLE_SLOTS) saturate); probing walks forward one slot
// at a time past slots holding other keys. An accepted item passes through the
// registered hash, the registered memory read of its home slot and the result
// register, with one more memory read for each further slot probed, and loads
// into the output register once that is free; the single read port of the slot
// memory, read once per cycle, paces the further slots. A walk over every active
// slot without a match or an empty slot ends in table full (insert) or not found
// (lookup). Non-positive keys answer bad key and leave the table alone. After
// reset the block zeroes the memory, one slot per cycle, with in_stall_o high;
// the configuration register can be written at any time the block is idle, and
// rewriting it does not clear the table. The result sits in an output register,
// so the next beat is taken while a result waits.
module hash_join_build_table #(
  parameter int unsigned TABLE_SLOTS = hjbt_pkg::TABLE_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [hjbt_pkg::CFG_W-1:0]      cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  hjbt_pkg::in_beat_t              in_data_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output hjbt_pkg::out_beat_t             out_data_o
);
  import hjbt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_SLOTS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_CHECK,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [CFG_W-1:0]    slots_log2_q;
  logic [AW-1:0]       clr_q;
  logic [AW-1:0]       slot_q;
  logic [AW:0]         cnt_q;
  logic [KEY_W-1:0]    key_q;
  logic                op_q;
  logic                flag_q;
  out_beat_t           res_q;
  out_beat_t           out_q;
  logic                out_valid_q;

  logic [4:0]          lg_raw;
  logic [4:0]          lg_eff;
  logic [AW-1:0]       mask;
  logic [AW:0]         n_slots;
  logic [AW-1:0]       home;
  logic [AW-1:0]       next_slot;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;
  store_wr_t           wr;
  entry_t              rdata;
  logic                in_acc;
  logic                bad_key;
  logic                hit;
  logic                empty;
  logic                last_probe;
  logic                out_free;
  logic                out_load;
  logic [AW+SLOT_OUT_W-1:0] slot_ext;

  // ---------------------------------------------------------------------------
  // configuration: slot count in use and the probe mask
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_log2_q <= SLOTS_LOG2_RST;
    end else if (cfg_we_i) begin
      slots_log2_q <= cfg_data_i;
    end
  end

  // zero means one, anything above the built table size saturates
  assign lg_raw  = (slots_log2_q == '0) ? 5'd1 : {1'b0, slots_log2_q};
  assign lg_eff  = (lg_raw > 5'(AW)) ? 5'(AW) : lg_raw;
  assign mask    = ~({AW{1'b1}} << lg_eff);
  assign n_slots = (AW + 1)'(1) << lg_eff;

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign bad_key    = in_data_i.join_key[31] || (in_data_i.join_key == '0);

  hjbt_hash #(
    .AW (AW)
  ) u_hash (
    .clk_i  (clk_i),
    .load_i (in_acc),
    .key_i  (in_data_i.join_key),
    .mask_i (mask),
    .home_o (home)
  );

  // ---------------------------------------------------------------------------
  // probe datapath: one slot compared per cycle
  // ---------------------------------------------------------------------------
  assign next_slot  = (slot_q + AW'(1)) & mask;
  // home slot is read in the cycle after accept, later slots while checking
  assign raddr      = (state_q == S_HOME) ? home : next_slot;
  assign hit        = (rdata.key == key_q);
  assign empty      = (rdata.key == '0);
  assign last_probe = ((cnt_q + (AW + 1)'(1)) == n_slots);

  // write port: zeroing sweep after reset, or the insert itself
  always_comb begin
    wr          = '0;
    waddr       = slot_q;
    if (state_q == S_CLEAR) begin
      wr.we     = 1'b1;
      waddr     = clr_q;
    end else if (state_q == S_CHECK && op_q == OP_INSERT && (hit || empty)) begin
      wr.we         = 1'b1;
      wr.wdata.key  = key_q;
      wr.wdata.flag = flag_q;
    end
  end

  hjbt_store #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .AW          (AW)
  ) u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .waddr_i (waddr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // slot index reported as its low bits, zero extended for small tables
  assign slot_ext = {SLOT_OUT_W'(0), slot_q};

  // output register can take a new result this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  // finished result moves into the output register
  assign out_load = (state_q == S_DONE) && out_free;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      slot_q      <= '0;
      cnt_q       <= '0;
      key_q       <= '0;
      op_q        <= 1'b0;
      flag_q      <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // new result loaded, or the waiting one taken downstream
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == {AW{1'b1}}) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_acc) begin
            key_q  <= in_data_i.join_key[KEY_W-1:0];
            op_q   <= in_data_i.operation;
            flag_q <= (in_data_i.type_prefix == PROMO_WORD);
            if (bad_key) begin
              res_q.status     <= ST_BAD_KEY;
              res_q.slot_index <= '0;
              res_q.promo_flag <= 1'b0;
              state_q          <= S_DONE;
            end else begin
              state_q <= S_HOME;
            end
          end
        end

        S_HOME: begin
          // home slot read is in flight
          slot_q  <= home;
          cnt_q   <= '0;
          state_q <= S_CHECK;
        end

        S_CHECK: begin
          if (hit) begin
            res_q.slot_index <= slot_ext[SLOT_OUT_W-1:0];
            if (op_q == OP_INSERT) begin
              res_q.status     <= ST_UPDATED;
              res_q.promo_flag <= flag_q;
            end else begin
              res_q.status     <= ST_FOUND;
              res_q.promo_flag <= rdata.flag;
            end
            state_q <= S_DONE;
          end else if (empty) begin
            if (op_q == OP_INSERT) begin
              res_q.status     <= ST_INSERTED;
              res_q.slot_index <= slot_ext[SLOT_OUT_W-1:0];
              res_q.promo_flag <= flag_q;
            end else begin
              res_q.status     <= ST_MISS;
              res_q.slot_index <= '0;
              res_q.promo_flag <= 1'b0;
            end
            state_q <= S_DONE;
          end else if (last_probe) begin
            // every active slot holds another key
            res_q.status     <= (op_q == OP_INSERT) ? ST_FULL : ST_MISS;
            res_q.slot_index <= '0;
            res_q.promo_flag <= 1'b0;
            state_q          <= S_DONE;
          end else begin
            // next slot read is issued on this edge
            slot_q <= next_slot;
            cnt_q  <= cnt_q + (AW + 1)'(1);
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // the memory is only written by the zeroing sweep or a deciding insert probe
  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we |-> (state_q == S_CLEAR || (state_q == S_CHECK && op_q == OP_INSERT)))
    else $error("slot memory written outside clear or insert");

  // the probe walk never visits more slots than are active
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (cnt_q < n_slots))
    else $error("probe count beyond active slots");

  // a waiting result is never overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_q == $past(out_q)))
    else $error("pending result overwritten");

  // no beat is taken before the zeroing sweep has finished
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> in_stall_o)
    else $error("input accepted during clearing pass");

endmodule

// ===== test/hash_join_build_table_tb.sv =====
`timescale 1ns / 100ps
// hash_join_build_table_tb: self-checking testbench for the hash join build table
// keeps its own copy of the slot table to predict every result beat
// depends on hjbt_pkg and hash_join_build_table
module hash_join_build_table_tb;
  import hjbt_pkg::*;

  localparam int unsigned SLOT_COUNT = 1024;
  localparam int unsigned POOL_SIZE  = 48;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_BEATS = 150;
  // golden-ratio multiplier of the home slot hash
  localparam logic [31:0] MULT_GOLDEN = 32'd2654435761;
  // "PROMO", first byte in the top bits
  localparam logic [39:0] PROMO_TEXT  = 40'h50524F4D4F;
  // table sizes per random phase; the last phase picks one at random
  localparam logic [3:0] PHASE_CFG [0:PHASES-1] = '{
    4'd10, 4'd1, 4'd3, 4'd6, 4'd15, 4'd2, 4'd4, 4'd0
  };

  // clock, reset and block-facing signals, all known from time zero
  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we = 1'b0;
  logic [3:0] cfg_data = '0;
  logic      feed_valid = 1'b0;
  in_beat_t  feed_beat = '0;
  logic      feed_stall;
  logic      result_valid;
  logic      out_stall = 1'b0;
  out_beat_t result_beat;

  // predictor state: mirror of the slot store and the size register
  logic [30:0] key_mirror [SLOT_COUNT];
  logic        flag_mirror [SLOT_COUNT];
  logic [3:0]  slots_log2;

  // predicted beats, oldest first
  out_beat_t pending_results[$];
  logic [31:0] key_pool [POOL_SIZE];

  // idle pressure in percent, changed between phases
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;

  always #5 clk_i = ~clk_i;

  hash_join_build_table #(
    .TABLE_SLOTS (SLOT_COUNT)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (feed_valid),
    .in_stall_o  (feed_stall),
    .in_data_i   (feed_beat),
    .out_valid_o (result_valid),
    .out_stall_i (out_stall),
    .out_data_o  (result_beat)
  );

  // one line per mismatch, output capped so a broken block cannot flood the log
  task automatic report_mismatch(input string msg);
    if (error_count < 100) $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic in_beat_t make_beat(input op_e op, input logic [31:0] key,
                                         input logic [39:0] prefix);
    in_beat_t b;
    b.operation   = op;
    b.join_key    = key;
    b.type_prefix = prefix;
    return b;
  endfunction

  // probe the mirror exactly as the block walks its table, update it on insert
  function automatic out_beat_t predict_probe(input in_beat_t b);
    out_beat_t   r;
    logic [31:0] raw;
    logic [31:0] hashed;
    int unsigned lg;
    int unsigned n;
    int unsigned mask;
    int unsigned slot;
    int unsigned probe;
    bit          hit;
    bit          empty;
    logic        flag;
    r.status     = ST_BAD_KEY;
    r.slot_index = '0;
    r.promo_flag = 1'b0;
    raw = b.join_key;
    // zero and negative keys leave the table alone
    if (raw[31] || raw == 32'd0) return r;
    // register value 0 counts as one bit, oversize saturates to the table
    lg = slots_log2;
    if (lg == 0) lg = 1;
    n = 1 << lg;
    while (n > SLOT_COUNT) n = n >> 1;
    mask   = n - 1;
    hashed = raw * MULT_GOLDEN;
    slot   = hashed & mask;
    hit    = 1'b0;
    empty  = 1'b0;
    for (probe = 0; probe < n; probe++) begin
      if (key_mirror[slot] == raw[30:0]) begin
        hit = 1'b1;
        break;
      end
      if (key_mirror[slot] == 31'd0) begin
        empty = 1'b1;
        break;
      end
      slot = (slot + 1) & mask;
    end
    if (b.operation == OP_INSERT) begin
      if (hit || empty) begin
        flag = (b.type_prefix == PROMO_TEXT);
        key_mirror[slot]  = raw[30:0];
        flag_mirror[slot] = flag;
        if (hit) r.status = ST_UPDATED;
        else r.status = ST_INSERTED;
        r.slot_index = slot[9:0];
        r.promo_flag = flag;
      end else begin
        r.status = ST_FULL;
      end
    end else begin
      if (hit) begin
        r.status     = ST_FOUND;
        r.slot_index = slot[9:0];
        r.promo_flag = flag_mirror[slot];
      end else begin
        r.status = ST_MISS;
      end
    end
    return r;
  endfunction

  // offer one beat, hold it until taken, then queue its prediction;
  // valid is only lowered in idle cycles so back-to-back beats keep it high
  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      feed_valid <= 1'b0;
      @(posedge clk_i);
    end
    feed_valid <= 1'b1;
    feed_beat  <= b;
    do @(posedge clk_i); while (feed_stall);
    pending_results.insert(pending_results.size(), predict_probe(b));
  endtask

  // drop valid and wait until every predicted beat has come back
  task automatic settle_idle();
    feed_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // size register is only written with nothing in flight
  task automatic write_slots_log2(input logic [3:0] value);
    settle_idle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    slots_log2 = value;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 60;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 60;
      end
      default: begin
        send_idle_pct  = 18;
        recv_stall_pct = 18;
      end
    endcase
  endtask

  // result side: take a beat when valid and not stalled, check it, pick next stall
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && result_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat status %0d with nothing pending",
                                  result_beat.status));
      end else begin
        want = pending_results.pop_front();
        if (result_beat.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    result_beat.status, want.status));
        if (result_beat.slot_index !== want.slot_index)
          report_mismatch($sformatf("slot_index got %0d want %0d",
                                    result_beat.slot_index, want.slot_index));
        if (result_beat.promo_flag !== want.promo_flag)
          report_mismatch($sformatf("promo_flag got %0d want %0d",
                                    result_beat.promo_flag, want.promo_flag));
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // new keys, updates, hits and misses at the reset size, key and prefix extremes
  task automatic test_insert_lookup();
    set_idling(0);
    send_beat(make_beat(OP_INSERT, 32'd1, PROMO_TEXT));
    // one letter off, flag must clear on the update
    send_beat(make_beat(OP_INSERT, 32'd1, 40'h50524F4D50));
    send_beat(make_beat(OP_LOOKUP, 32'd1, PROMO_TEXT));
    send_beat(make_beat(OP_LOOKUP, 32'h7FFF_FFFF, 40'd0));
    send_beat(make_beat(OP_INSERT, 32'h7FFF_FFFF, 40'hFF_FFFF_FFFF));
    send_beat(make_beat(OP_INSERT, 32'd2, 40'd0));
    send_beat(make_beat(OP_LOOKUP, 32'h7FFF_FFFF, 40'hFF_FFFF_FFFF));
    send_beat(make_beat(OP_INSERT, 32'd2, PROMO_TEXT));
    send_beat(make_beat(OP_LOOKUP, 32'd2, 40'd0));
  endtask

  // zero and negative keys on both operations answer bad key
  task automatic test_bad_keys();
    set_idling(3);
    send_beat(make_beat(OP_INSERT, 32'd0, PROMO_TEXT));
    send_beat(make_beat(OP_LOOKUP, 32'd0, 40'd0));
    send_beat(make_beat(OP_INSERT, 32'h8000_0000, PROMO_TEXT));
    send_beat(make_beat(OP_LOOKUP, 32'hFFFF_FFFF, PROMO_TEXT));
    // key 1 must still be there untouched
    send_beat(make_beat(OP_LOOKUP, 32'd1, 40'd0));
  endtask

  // two-slot table: fill it, overflow, walk a full table on a miss, then saturate
  task automatic test_table_full();
    set_idling(0);
    write_slots_log2(4'd0);
    send_beat(make_beat(OP_INSERT, 32'd3, PROMO_TEXT));
    send_beat(make_beat(OP_INSERT, 32'd4, 40'd0));
    send_beat(make_beat(OP_INSERT, 32'd5, PROMO_TEXT));
    send_beat(make_beat(OP_LOOKUP, 32'd6, 40'd0));
    send_beat(make_beat(OP_LOOKUP, 32'd4, 40'd0));
    send_beat(make_beat(OP_INSERT, 32'd4, PROMO_TEXT));
    // oversize register value falls back to the full table, old entries stay
    write_slots_log2(4'd15);
    send_beat(make_beat(OP_LOOKUP, 32'd1, 40'd0));
    send_beat(make_beat(OP_LOOKUP, 32'd3, 40'd0));
    send_beat(make_beat(OP_INSERT, 32'd5, PROMO_TEXT));
  endtask

  // mostly inserts and lookups over a small key pool, some noise and bad keys
  function automatic in_beat_t random_beat();
    int unsigned pick;
    logic [31:0] key;
    logic [39:0] prefix;
    op_e         op;
    pick = $urandom_range(0, 99);
    op   = OP_INSERT;
    if ($urandom_range(0, 99) >= 55) op = OP_LOOKUP;
    if (pick < 8) begin
      key = $urandom();
      op  = op_e'($urandom_range(0, 1));
    end else if (pick < 12) begin
      case ($urandom_range(0, 3))
        0: key = 32'd0;
        1: key = 32'h8000_0000;
        2: key = 32'hFFFF_FFFF;
        default: key = {1'b1, 31'($urandom())};
      endcase
    end else if (pick < 18) begin
      key = {1'b0, 31'($urandom())};
      if (key == 32'd0) key = 32'd1;
    end else begin
      key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: prefix = PROMO_TEXT;
      5, 6: prefix = PROMO_TEXT ^ (40'd1 << $urandom_range(0, 39));
      default: prefix = {8'($urandom()), 32'($urandom())};
    endcase
    return make_beat(op, key, prefix);
  endfunction

  // phases of random traffic, each with its own table size and idling
  task automatic test_random_traffic();
    int unsigned ph;
    int unsigned i;
    logic [3:0]  size_cfg;
    key_pool[0] = 32'd1;
    key_pool[1] = 32'h7FFF_FFFF;
    for (i = 2; i < POOL_SIZE; i++) begin
      key_pool[i] = {1'b0, 31'($urandom())};
      if (key_pool[i] == 32'd0) key_pool[i] = 32'd7;
    end
    for (ph = 0; ph < PHASES; ph++) begin
      size_cfg = PHASE_CFG[ph];
      if (ph == PHASES - 1) size_cfg = 4'($urandom_range(0, 15));
      write_slots_log2(size_cfg);
      set_idling(ph);
      for (i = 0; i < PHASE_BEATS; i++) send_beat(random_beat());
    end
  endtask

  initial begin
    for (int s = 0; s < SLOT_COUNT; s++) begin
      key_mirror[s]  = '0;
      flag_mirror[s] = 1'b0;
    end
    slots_log2 = 4'd10;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // first beat waits out the clearing pass through the stall
    test_insert_lookup();
    test_bad_keys();
    test_table_full();
    test_random_traffic();
    settle_idle();
    // grace period for any stray beat
    repeat (64) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== hash_join_build_table.f =====
rtl/core/hjbt_pkg.sv
rtl/core/hjbt_hash.sv
rtl/core/hjbt_store.sv
rtl/core/hash_join_build_table.sv
test/hash_join_build_table_tb.sv
